// ----- sv/pcon_pkg.sv -----
package pcon_pkg;

    // input word field widths
    localparam int IN_W = 20;

    // default stored coordinate width
    localparam int COORD_BITS_DEF = 21;

    // margin register
    localparam int MARGIN_W = 16;
    localparam logic [MARGIN_W-1:0] MARGIN_RST = 16'd192;

    // config bus
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_MARGIN = 1'b0;

    // digit width of the iterative squared-distance multiplier
    localparam int DIGIT_W = 16;

    // edge job queue
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic clr;
        logic edge_en;
        logic emit;
    } t_job_ctl;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PROD,
        BK_SUM,
        BK_ITER,
        BK_CMP,
        BK_EMIT
    } t_bk_state;

endpackage

// ----- sv/pcon_if.sv -----
interface pcon_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [pcon_pkg::IN_W-1:0]  query_x;
    logic signed [pcon_pkg::IN_W-1:0]  query_y;
    logic signed [pcon_pkg::IN_W-1:0]  vertex_x;
    logic signed [pcon_pkg::IN_W-1:0]  vertex_y;
    logic                              first_vertex;
    logic                              last_vertex;

    modport source (
        output valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, query_x, query_y, vertex_x, vertex_y, first_vertex, last_vertex,
        output ready
    );
endinterface

interface pcon_out_if;
    logic valid;
    logic ready;
    logic hit;
    logic inside_res;
    logic near_edge;

    modport source (
        output valid, hit, inside_res, near_edge,
        input  ready
    );
    modport sink (
        input  valid, hit, inside_res, near_edge,
        output ready
    );
endinterface

// ----- sv/pcon_queue.sv -----
module pcon_queue #(
    parameter int W = 126
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [W-1:0]         i_data,
    input  pcon_pkg::t_job_ctl   i_ctl,
    input  logic                 i_pop,
    output logic [W-1:0]         o_data,
    output pcon_pkg::t_job_ctl   o_ctl,
    output logic                 o_empty,
    output logic                 o_full
);
    localparam int DEPTH = pcon_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]       r_data [DEPTH];
    pcon_pkg::t_job_ctl r_ctl  [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_data[r_rd_ptr];
    assign o_ctl   = r_ctl[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
            r_ctl[r_wr_ptr]  <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_W'(DEPTH)) || i_pop)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("job queue underflow");

endmodule

// ----- sv/pcon_front.sv -----
module pcon_front #(
    parameter int COORD_BITS = pcon_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    pcon_in_if.sink                 i_vtx,
    input  logic                    i_q_full,
    output logic                    o_push,
    output pcon_pkg::t_job_ctl      o_ctl,
    output logic [6*COORD_BITS-1:0] o_data
);
    localparam int EW = (COORD_BITS > pcon_pkg::IN_W) ? COORD_BITS : pcon_pkg::IN_W;

    logic signed [EW-1:0]   vx_e, vy_e, qx_e, qy_e;
    logic [COORD_BITS-1:0]  vx, vy, qx, qy;
    logic                   accept;

    logic [COORD_BITS-1:0]  r_first_x, r_first_y;
    logic [COORD_BITS-1:0]  r_prev_x, r_prev_y;
    logic [COORD_BITS-1:0]  r_qx, r_qy;
    logic                   r_pend;

    // sign extend, then wrap to the stored width
    assign vx_e = EW'(i_vtx.vertex_x);
    assign vy_e = EW'(i_vtx.vertex_y);
    assign qx_e = EW'(i_vtx.query_x);
    assign qy_e = EW'(i_vtx.query_y);
    assign vx   = vx_e[COORD_BITS-1:0];
    assign vy   = vy_e[COORD_BITS-1:0];
    assign qx   = qx_e[COORD_BITS-1:0];
    assign qy   = qy_e[COORD_BITS-1:0];

    assign i_vtx.ready = !r_pend && !i_q_full;
    assign accept      = i_vtx.valid && i_vtx.ready;

    // job word: {ax, ay, bx, by, px, py}
    always_comb begin
        o_push = 1'b0;
        o_ctl  = '0;
        o_data = '0;
        if (r_pend) begin
            // closing edge back to the first vertex
            o_push        = !i_q_full;
            o_ctl.edge_en = 1'b1;
            o_ctl.emit    = 1'b1;
            o_data        = {r_prev_x, r_prev_y, r_first_x, r_first_y, r_qx, r_qy};
        end else if (accept) begin
            o_push = 1'b1;
            if (i_vtx.first_vertex) begin
                o_ctl.clr = 1'b1;
            end else begin
                o_ctl.edge_en = 1'b1;
                o_data        = {r_prev_x, r_prev_y, vx, vy, r_qx, r_qy};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x <= '0;
            r_first_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_qx      <= '0;
            r_qy      <= '0;
            r_pend    <= 1'b0;
        end else begin
            if (accept) begin
                r_prev_x <= vx;
                r_prev_y <= vy;
                r_pend   <= i_vtx.last_vertex;
                if (i_vtx.first_vertex) begin
                    r_first_x <= vx;
                    r_first_y <= vy;
                    r_qx      <= qx;
                    r_qy      <= qy;
                end
            end else if (r_pend && !i_q_full) begin
                r_pend <= 1'b0;
            end
        end
    end

endmodule

// ----- sv/pcon_back.sv -----
module pcon_back #(
    parameter int COORD_BITS = pcon_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [pcon_pkg::MARGIN_W-1:0]   i_margin,
    input  logic [6*COORD_BITS-1:0]         i_data,
    input  pcon_pkg::t_job_ctl              i_ctl,
    input  logic                            i_empty,
    output logic                            o_pop,
    pcon_out_if.source                      o_res
);
    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int PW   = 2 * DW;
    localparam int SW   = PW + 1;
    localparam int MQW  = 2 * pcon_pkg::MARGIN_W;
    localparam int MW   = (SW > MQW) ? SW : MQW;
    localparam int DG   = pcon_pkg::DIGIT_W;
    localparam int NDIG = (MW + DG - 1) / DG;
    localparam int SRW  = NDIG * DG;
    localparam int PRW  = (2 * SW > SW + MQW) ? 2 * SW : SW + MQW;
    localparam int CNW  = $clog2(NDIG + 1);

    pcon_pkg::t_bk_state r_state, n_state;

    logic signed [CB-1:0] j_ax, j_ay, j_bx, j_by, j_px, j_py;

    logic signed [DW-1:0] r_abx, r_aby, r_apx, r_apy, r_bpx, r_bpy;
    logic                 r_emit;

    logic signed [PW-1:0] r_p_len_x, r_p_len_y, r_p_dot_x, r_p_dot_y;
    logic signed [PW-1:0] r_p_da_x, r_p_da_y, r_p_db_x, r_p_db_y;
    logic signed [PW-1:0] r_p_cr_a, r_p_cr_b, r_p_t1, r_p_t2;
    logic                 r_cross, r_aby_neg;

    logic signed [SW-1:0] dot, len2, da2, db2, cr;
    logic [SW-1:0]        c_mag;
    logic                 toggle, dot_le0, dot_ge_len, da_lt, db_lt;

    logic [SW-1:0]        r_mc_a, r_mc_b;
    logic [SRW-1:0]       r_sr_a, r_sr_b;
    logic [PRW-1:0]       r_acc_a, r_acc_b;
    logic [CNW-1:0]       r_cnt;
    logic [DG-1:0]        dig_a, dig_b;
    logic [SW+DG-1:0]     pp_a, pp_b;

    logic [MQW-1:0]       r_m2;
    logic                 r_parity, r_near;
    logic                 r_out_valid, r_hit, r_inside, r_near_out;
    logic                 out_free;

    assign j_ax = i_data[6*CB-1 -: CB];
    assign j_ay = i_data[5*CB-1 -: CB];
    assign j_bx = i_data[4*CB-1 -: CB];
    assign j_by = i_data[3*CB-1 -: CB];
    assign j_px = i_data[2*CB-1 -: CB];
    assign j_py = i_data[CB-1 -: CB];

    // per-edge sums and the short-range compares
    assign dot   = SW'(r_p_dot_x) + SW'(r_p_dot_y);
    assign len2  = SW'(r_p_len_x) + SW'(r_p_len_y);
    assign da2   = SW'(r_p_da_x) + SW'(r_p_da_y);
    assign db2   = SW'(r_p_db_x) + SW'(r_p_db_y);
    assign cr    = SW'(r_p_cr_a) - SW'(r_p_cr_b);
    assign c_mag = cr[SW-1] ? $unsigned(-cr) : $unsigned(cr);

    // crossing: ordering flips with the sign of the edge's dy
    assign toggle     = r_cross && (r_aby_neg ? (r_p_t1 > r_p_t2) : (r_p_t1 < r_p_t2));
    assign dot_le0    = dot[SW-1] || (dot == '0);
    assign dot_ge_len = (dot >= len2);
    assign da_lt      = MW'($unsigned(da2)) < MW'(r_m2);
    assign db_lt      = MW'($unsigned(db2)) < MW'(r_m2);

    // one digit per cycle, most significant first
    assign dig_a = r_sr_a[SRW-1 -: DG];
    assign dig_b = r_sr_b[SRW-1 -: DG];
    assign pp_a  = (SW+DG)'(r_mc_a) * (SW+DG)'(dig_a);
    assign pp_b  = (SW+DG)'(r_mc_b) * (SW+DG)'(dig_b);

    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcon_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            pcon_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_ctl.edge_en) begin
                        n_state = pcon_pkg::BK_PROD;
                    end else if (i_ctl.emit) begin
                        n_state = pcon_pkg::BK_EMIT;
                    end
                end
            end
            pcon_pkg::BK_PROD: begin
                n_state = pcon_pkg::BK_SUM;
            end
            pcon_pkg::BK_SUM: begin
                if (!dot_le0 && !dot_ge_len) begin
                    n_state = pcon_pkg::BK_ITER;
                end else begin
                    n_state = r_emit ? pcon_pkg::BK_EMIT : pcon_pkg::BK_IDLE;
                end
            end
            pcon_pkg::BK_ITER: begin
                if (r_cnt == '0) begin
                    n_state = pcon_pkg::BK_CMP;
                end
            end
            pcon_pkg::BK_CMP: begin
                n_state = r_emit ? pcon_pkg::BK_EMIT : pcon_pkg::BK_IDLE;
            end
            pcon_pkg::BK_EMIT: begin
                if (out_free) begin
                    n_state = pcon_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = pcon_pkg::BK_IDLE;
            end
        endcase
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_m2 <= MQW'(i_margin) * MQW'(i_margin);
        if (r_state == pcon_pkg::BK_IDLE && !i_empty) begin
            r_emit <= i_ctl.emit;
            r_abx  <= DW'(j_bx) - DW'(j_ax);
            r_aby  <= DW'(j_by) - DW'(j_ay);
            r_apx  <= DW'(j_px) - DW'(j_ax);
            r_apy  <= DW'(j_py) - DW'(j_ay);
            r_bpx  <= DW'(j_px) - DW'(j_bx);
            r_bpy  <= DW'(j_py) - DW'(j_by);
        end
        if (r_state == pcon_pkg::BK_PROD) begin
            r_p_len_x <= PW'(r_abx) * PW'(r_abx);
            r_p_len_y <= PW'(r_aby) * PW'(r_aby);
            r_p_dot_x <= PW'(r_apx) * PW'(r_abx);
            r_p_dot_y <= PW'(r_apy) * PW'(r_aby);
            r_p_da_x  <= PW'(r_apx) * PW'(r_apx);
            r_p_da_y  <= PW'(r_apy) * PW'(r_apy);
            r_p_db_x  <= PW'(r_bpx) * PW'(r_bpx);
            r_p_db_y  <= PW'(r_bpy) * PW'(r_bpy);
            r_p_cr_a  <= PW'(r_apx) * PW'(r_aby);
            r_p_cr_b  <= PW'(r_apy) * PW'(r_abx);
            r_p_t1    <= PW'(r_bpx) * PW'(r_aby);
            r_p_t2    <= PW'(r_abx) * PW'(r_bpy);
            r_cross   <= r_bpy[DW-1] ^ r_apy[DW-1];
            r_aby_neg <= r_aby[DW-1];
        end
        if (r_state == pcon_pkg::BK_SUM) begin
            // perpendicular case: cross^2 against margin^2 * len^2
            r_mc_a  <= c_mag;
            r_sr_a  <= SRW'(c_mag);
            r_mc_b  <= $unsigned(len2);
            r_sr_b  <= SRW'(r_m2);
            r_acc_a <= '0;
            r_acc_b <= '0;
            r_cnt   <= CNW'(NDIG - 1);
        end
        if (r_state == pcon_pkg::BK_ITER) begin
            r_acc_a <= (r_acc_a << DG) + PRW'(pp_a);
            r_acc_b <= (r_acc_b << DG) + PRW'(pp_b);
            r_sr_a  <= r_sr_a << DG;
            r_sr_b  <= r_sr_b << DG;
            r_cnt   <= r_cnt - 1'b1;
        end
        if (r_state == pcon_pkg::BK_EMIT && out_free) begin
            r_hit      <= r_parity | r_near;
            r_inside   <= r_parity;
            r_near_out <= r_near;
        end
    end

    // accumulators and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity    <= 1'b0;
            r_near      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == pcon_pkg::BK_IDLE && !i_empty && i_ctl.clr) begin
                r_parity <= 1'b0;
                r_near   <= 1'b0;
            end
            if (r_state == pcon_pkg::BK_SUM) begin
                r_parity <= r_parity ^ toggle;
                if (dot_le0) begin
                    r_near <= r_near | da_lt;
                end else if (dot_ge_len) begin
                    r_near <= r_near | db_lt;
                end
            end
            if (r_state == pcon_pkg::BK_CMP) begin
                r_near <= r_near | (r_acc_a < r_acc_b);
            end
            if (r_state == pcon_pkg::BK_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.hit        = r_hit;
    assign o_res.inside_res = r_inside;
    assign o_res.near_edge  = r_near_out;

    a_cmp_after_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcon_pkg::BK_CMP) |-> ($past(r_state) == pcon_pkg::BK_ITER))
        else $error("compare entered without finishing the digit loop");

    a_emit_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcon_pkg::BK_EMIT) |-> r_emit)
        else $error("result stage entered for a job without emit");

endmodule

// ----- sv/polygon_contains_or_near_point.sv -----
// polygon containment or proximity test, one vertex word per accepted handshake
// i_vtx: vertex words; first_vertex latches the query point and clears the
//   parity and near flags, last_vertex also closes the polygon back to the first vertex
// o_res: one result word (hit, inside_res, near_edge) per last_vertex word
// apb port: register 0 at address 0 is the 16-bit margin, reset 192 (coordinate units)
// throughput: the front takes a vertex word every cycle until the four-entry edge
//   queue fills, and a last vertex holds it off until its closing edge is queued;
//   the back takes one edge at a time through PROD and SUM, and through the ITER
//   digit loop and CMP when the point projects inside the segment, NDIG digits with
//   NDIG = ceil(max(2*COORD_BITS+3, 32) / 16), 3 at the default width
// result path: after the last vertex word the back runs the last edge, the closing
//   edge and EMIT; a lone vertex that is first and last has only the closing edge
// reset: synchronous, clears held vertices, query point, flags and the queue,
//   and restores the margin
// a stalled o_res holds its word in the output register; the back then waits and
//   the queue and front keep taking words until the queue is full
module polygon_contains_or_near_point #(
    parameter int COORD_BITS = pcon_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pcon_in_if.sink                        i_vtx,
    pcon_out_if.source                     o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcon_pkg::PADDR_W-1:0]   paddr,
    input  logic [pcon_pkg::PDATA_W-1:0]   pwdata,
    output logic [pcon_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    localparam int JW = 6 * COORD_BITS;

    // margin register
    logic [pcon_pkg::MARGIN_W-1:0] r_margin;
    logic                          reg_sel;

    // edge jobs from front to back
    logic                  push, pop, q_full, q_empty;
    pcon_pkg::t_job_ctl    push_ctl, pop_ctl;
    logic [JW-1:0]         push_data, pop_data;

    assign reg_sel = (paddr[pcon_pkg::PADDR_W-1:2] == pcon_pkg::REG_MARGIN);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? pcon_pkg::PDATA_W'(r_margin) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= pcon_pkg::MARGIN_RST;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_margin <= pwdata[pcon_pkg::MARGIN_W-1:0];
        end
    end

    // front: latches query and vertices, turns each vertex into edge jobs
    pcon_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vtx    (i_vtx),
        .i_q_full (q_full),
        .o_push   (push),
        .o_ctl    (push_ctl),
        .o_data   (push_data)
    );

    // short queue so front and back stall independently
    pcon_queue #(
        .W (JW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_ctl   (push_ctl),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_ctl   (pop_ctl),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: crossing parity, distance tests, result register
    pcon_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_margin (r_margin),
        .i_data   (pop_data),
        .i_ctl    (pop_ctl),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

// ----- verif/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // field limits of a 20-bit signed coordinate
    localparam longint COORD_MAX = (64'sd1 <<< (pcon_pkg::IN_W - 1)) - 1;
    localparam longint COORD_MIN = -(64'sd1 <<< (pcon_pkg::IN_W - 1));

    // margin register sits at byte address 4 * index
    localparam logic [pcon_pkg::PADDR_W-1:0] MARGIN_ADDR = {pcon_pkg::REG_MARGIN, 2'b00};

    // words of random stimulus per margin setting, six settings in all
    localparam int PHASE_WORDS = 325;
    // cycles the receiver refuses results during the pressure test
    localparam int LONG_HOLD = 400;
    // quiet cycles after the last result before reprogramming or ending;
    // covers a full edge queue behind a polygon with no last vertex
    localparam int SETTLE_CYCLES = 100;
    localparam int DRAIN_LIMIT = 50000;

    typedef struct {
        logic signed [pcon_pkg::IN_W-1:0] qx;
        logic signed [pcon_pkg::IN_W-1:0] qy;
        logic signed [pcon_pkg::IN_W-1:0] vx;
        logic signed [pcon_pkg::IN_W-1:0] vy;
        logic                             first;
        logic                             last;
    } t_vertex_word;

    typedef struct {
        logic hit;
        logic inside_res;
        logic near_edge;
    } t_verdict;

    // tracks the polygon being streamed and holds the verdicts still owed by the block
    class hit_scoreboard;
        longint start_x, start_y, prev_x, prev_y, probe_x, probe_y;
        bit     parity, near_seen;
        longint margin;
        t_verdict verdicts_due[$];
        int errors, checked, inside_cnt, near_cnt;

        function new();
            start_x = 0; start_y = 0; prev_x = 0; prev_y = 0;
            probe_x = 0; probe_y = 0;
            parity = 1'b0; near_seen = 1'b0;
            margin = pcon_pkg::MARGIN_RST;
            errors = 0; checked = 0; inside_cnt = 0; near_cnt = 0;
        endfunction

        function void set_margin(logic [pcon_pkg::MARGIN_W-1:0] m);
            margin = m;
        endfunction

        // crossing test and squared-distance test for the segment a -> b
        function void cross_edge(longint ax, longint ay, longint bx, longint by);
            longint px, py, abx, aby, apx, apy, bpx, bpy;
            longint d, lhs, rhs, dot, len2, m2, cr;
            logic [127:0] cw, mw, lw;
            px = probe_x;
            py = probe_y;
            abx = bx - ax; aby = by - ay;
            apx = px - ax; apy = py - ay;
            m2 = margin * margin;
            if ((by > py) != (ay > py)) begin
                // crossing abscissa compare, sign of the denominator folded in
                d = ay - by;
                lhs = (px - bx) * d;
                rhs = (ax - bx) * (py - by);
                if (d > 0 ? lhs < rhs : lhs > rhs)
                    parity ^= 1'b1;
            end
            dot = apx * abx + apy * aby;
            len2 = abx * abx + aby * aby;
            if (dot <= 0) begin
                // before the start, also the zero-length edge
                if (apx * apx + apy * apy < m2)
                    near_seen = 1'b1;
            end else if (dot >= len2) begin
                bpx = px - bx;
                bpy = py - by;
                if (bpx * bpx + bpy * bpy < m2)
                    near_seen = 1'b1;
            end else begin
                // projection inside the segment: cross^2 < m^2 * len^2, wide compare
                cr = apx * aby - apy * abx;
                if (cr < 0)
                    cr = -cr;
                cw = cr;
                mw = m2;
                lw = len2;
                if (cw * cw < mw * lw)
                    near_seen = 1'b1;
            end
        endfunction

        // coordinates are 20 bits and stored in 21, so no wrap is needed
        function void take_vertex(t_vertex_word w);
            longint vx, vy;
            t_verdict v;
            vx = w.vx;
            vy = w.vy;
            if (w.first) begin
                probe_x = w.qx;
                probe_y = w.qy;
                start_x = vx;
                start_y = vy;
                parity = 1'b0;
                near_seen = 1'b0;
            end else begin
                cross_edge(prev_x, prev_y, vx, vy);
            end
            if (w.last) begin
                cross_edge(vx, vy, start_x, start_y);
                v.hit = parity | near_seen;
                v.inside_res = parity;
                v.near_edge = near_seen;
                verdicts_due = {verdicts_due, v};
            end
            prev_x = vx;
            prev_y = vy;
        endfunction

        function void compare_verdict(t_verdict got);
            t_verdict want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result word: hit %b inside %b near %b",
                         $time, got.hit, got.inside_res, got.near_edge);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            checked++;
            if (want.inside_res) inside_cnt++;
            if (want.near_edge) near_cnt++;
            if (got.hit !== want.hit) begin
                $display("%0t: hit mismatch, expected %b actual %b",
                         $time, want.hit, got.hit);
                errors++;
            end
            if (got.inside_res !== want.inside_res) begin
                $display("%0t: inside_res mismatch, expected %b actual %b",
                         $time, want.inside_res, got.inside_res);
                errors++;
            end
            if (got.near_edge !== want.near_edge) begin
                $display("%0t: near_edge mismatch, expected %b actual %b",
                         $time, want.near_edge, got.near_edge);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    // apb side
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [pcon_pkg::PADDR_W-1:0] paddr;
    logic [pcon_pkg::PDATA_W-1:0] pwdata;
    logic [pcon_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    pcon_in_if  vtx_if ();
    pcon_out_if res_if ();

    polygon_contains_or_near_point dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hit_scoreboard board = new();

    // idle percentages per side, changed between phases
    int src_idle_pct = 28;
    int snk_idle_pct = 86;

    // long receiver hold-off, asked for by the stimulus and counted by the receiver
    int stall_asked = 0;
    int stall_served = 0;
    int hold_left = 0;

    int words_sent = 0;
    int margins_set = 0;

    t_vertex_word poly_buf[$];

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit, far above the slowest legal run
    initial begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // receiver: random back-pressure, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (stall_served != stall_asked) begin
            stall_served = stall_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready = 1'b0;
        end else begin
            res_if.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // result monitor, sampled on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            board.compare_verdict(t_verdict'{res_if.hit, res_if.inside_res,
                                             res_if.near_edge});
    end

    function automatic logic signed [pcon_pkg::IN_W-1:0] clamp_coord(longint v);
        if (v > COORD_MAX)
            return COORD_MAX[pcon_pkg::IN_W-1:0];
        if (v < COORD_MIN)
            return COORD_MIN[pcon_pkg::IN_W-1:0];
        return v[pcon_pkg::IN_W-1:0];
    endfunction

    // uniform in [-r, r]
    function automatic longint rand_offset(longint r);
        return longint'($urandom_range(int'(2 * r))) - r;
    endfunction

    function automatic t_vertex_word make_word(longint qx, longint qy, longint vx,
                                               longint vy, bit first, bit last);
        t_vertex_word w;
        w.qx = qx[pcon_pkg::IN_W-1:0];
        w.qy = qy[pcon_pkg::IN_W-1:0];
        w.vx = vx[pcon_pkg::IN_W-1:0];
        w.vy = vy[pcon_pkg::IN_W-1:0];
        w.first = first;
        w.last = last;
        return w;
    endfunction

    // offer one vertex word, with random idle cycles ahead of it; returns at the
    // falling edge after acceptance with valid still high
    task automatic send_vertex(input t_vertex_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            vtx_if.valid = 1'b0;
            @(negedge i_clk);
        end
        vtx_if.valid = 1'b1;
        vtx_if.query_x = w.qx;
        vtx_if.query_y = w.qy;
        vtx_if.vertex_x = w.vx;
        vtx_if.vertex_y = w.vy;
        vtx_if.first_vertex = w.first;
        vtx_if.last_vertex = w.last;
        @(posedge i_clk);
        while (!vtx_if.ready)
            @(posedge i_clk);
        board.take_vertex(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    // write the margin, read it back, and update the predictor
    task automatic program_margin(input logic [pcon_pkg::MARGIN_W-1:0] m);
        logic [pcon_pkg::PDATA_W-1:0] rd;
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = MARGIN_ADDR;
        // bits above the register width are don't-care
        pwdata = {(pcon_pkg::PDATA_W - pcon_pkg::MARGIN_W)'($urandom()), m};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        board.set_margin(m);
        @(negedge i_clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if (rd[pcon_pkg::MARGIN_W-1:0] !== m) begin
            $display("%0t: margin readback mismatch, expected %h actual %h",
                     $time, m, rd[pcon_pkg::MARGIN_W-1:0]);
            board.errors++;
        end
        margins_set++;
    endtask

    // stop offering, wait for every owed verdict, then let the edge queue run dry
    task automatic drain_results();
        int waited;
        vtx_if.valid = 1'b0;
        waited = 0;
        while (board.verdicts_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // one polygon into poly_buf; broken ones lose their first or last mark,
    // or get an early last
    task automatic build_polygon(input bit broken);
        int n, shape, q, roll;
        longint qx, qy, cx, cy, r, ox, oy;
        t_vertex_word w;
        poly_buf.delete();
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : $urandom_range(8, 1);
        qx = rand_offset(COORD_MAX);
        qy = rand_offset(COORD_MAX);
        roll = $urandom_range(99);
        // mostly tight polygons so the margin matters, a few spanning the field
        if (roll < 40)
            r = $urandom_range(600, 1);
        else if (roll < 70)
            r = $urandom_range(5000, 1);
        else if (roll < 90)
            r = $urandom_range(100000, 1);
        else
            r = 1 << pcon_pkg::IN_W;
        cx = qx + rand_offset(r / 2);
        cy = qy + rand_offset(r / 2);
        shape = $urandom_range(1);
        for (int k = 0; k < n; k++) begin
            if (shape == 0) begin
                // walk the quadrants around the center so the point tends to be inside
                q = (k * 4) / n;
                ox = $urandom_range(int'(r));
                oy = $urandom_range(int'(r));
                if (q == 1 || q == 2) ox = -ox;
                if (q >= 2) oy = -oy;
            end else begin
                ox = rand_offset(r);
                oy = rand_offset(r);
            end
            w.vx = clamp_coord(cx + ox);
            w.vy = clamp_coord(cy + oy);
            // query on non-first words is don't-care, so fill it with noise
            if (k == 0) begin
                w.qx = qx[pcon_pkg::IN_W-1:0];
                w.qy = qy[pcon_pkg::IN_W-1:0];
            end else begin
                w.qx = pcon_pkg::IN_W'($urandom());
                w.qy = pcon_pkg::IN_W'($urandom());
            end
            w.first = (k == 0);
            w.last = (k == n - 1);
            poly_buf = {poly_buf, w};
        end
        if (broken) begin
            case ($urandom_range(2))
                0: poly_buf[0].first = 1'b0;
                1: poly_buf[n-1].last = 1'b0;
                default: poly_buf[$urandom_range(n - 1)].last = 1'b1;
            endcase
        end
    endtask

    initial begin
        int roll;
        int phase_end;
        logic [pcon_pkg::MARGIN_W-1:0] margin_plan [6];
        t_vertex_word w;

        // every input known from time zero
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        vtx_if.valid = 1'b0;
        vtx_if.query_x = '0;
        vtx_if.query_y = '0;
        vtx_if.vertex_x = '0;
        vtx_if.vertex_y = '0;
        vtx_if.first_vertex = 1'b0;
        vtx_if.last_vertex = 1'b0;
        res_if.ready = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words, reset margin of 192 units
        // no first vertex since reset: edges start at the zeroed held state
        send_vertex(make_word(0, 0, 100, 0, 0, 0));
        send_vertex(make_word(0, 0, 0, 100, 0, 1));
        // single vertex on the point, then one far away
        send_vertex(make_word(160, -160, 160, -160, 1, 1));
        send_vertex(make_word(0, 0, COORD_MAX, COORD_MAX, 1, 1));
        // triangle across the whole field
        send_vertex(make_word(0, 0, COORD_MIN, COORD_MIN, 1, 0));
        send_vertex(make_word(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 0, 0));
        send_vertex(make_word(COORD_MAX, COORD_MIN, 0, COORD_MAX, 0, 1));
        // square with a repeated corner, a zero-length edge
        send_vertex(make_word(0, 0, -4000, -4000, 1, 0));
        send_vertex(make_word(0, 0, 4000, -4000, 0, 0));
        send_vertex(make_word(0, 0, 4000, -4000, 0, 0));
        send_vertex(make_word(0, 0, 4000, 4000, 0, 0));
        send_vertex(make_word(0, 0, -4000, 4000, 0, 1));
        // carry on past the last vertex without a new first
        send_vertex(make_word(999, 999, 3000, 0, 0, 0));
        send_vertex(make_word(-999, -999, 0, 3000, 0, 1));
        // point on a horizontal edge
        send_vertex(make_word(0, 0, -300, 0, 1, 0));
        send_vertex(make_word(0, 0, 300, 0, 0, 0));
        send_vertex(make_word(0, 0, 0, 300, 0, 1));
        // point at a field corner, close to the middle of a diagonal edge
        send_vertex(make_word(COORD_MIN, COORD_MAX, COORD_MIN + 100, COORD_MAX, 1, 0));
        send_vertex(make_word(0, 0, COORD_MIN, COORD_MAX - 100, 0, 0));
        send_vertex(make_word(0, 0, -500000, 500000, 0, 1));
        // single vertex at the opposite corner, on the point
        send_vertex(make_word(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1, 1));
        // single vertex exactly at the margin distance, not strictly inside it
        send_vertex(make_word(0, 0, 192, 0, 1, 1));
        drain_results();

        // margin extremes first, then ordinary values, ending back at the default
        margin_plan[0] = '1;
        margin_plan[1] = '0;
        margin_plan[2] = $urandom();
        margin_plan[3] = 1;
        margin_plan[4] = $urandom_range(2000, 100);
        margin_plan[5] = pcon_pkg::MARGIN_RST;

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin
                    src_idle_pct = 28;
                    snk_idle_pct = 86;
                end
                1: begin
                    src_idle_pct = 86;
                    snk_idle_pct = 28;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            program_margin(margin_plan[ph]);
            // full-rate sender against a stalled receiver fills the block
            if (ph == 2)
                stall_asked++;
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                roll = $urandom_range(99);
                if (roll < 92) begin
                    build_polygon(roll >= 80);
                    foreach (poly_buf[i])
                        send_vertex(poly_buf[i]);
                end else begin
                    // raw noise word, flags included
                    w.qx = pcon_pkg::IN_W'($urandom());
                    w.qy = pcon_pkg::IN_W'($urandom());
                    w.vx = pcon_pkg::IN_W'($urandom());
                    w.vy = pcon_pkg::IN_W'($urandom());
                    w.first = $urandom_range(1);
                    w.last = $urandom_range(1);
                    send_vertex(w);
                end
            end
            drain_results();
        end

        if (board.verdicts_due.size() != 0) begin
            $display("%0t: %0d expected result words never arrived",
                     $time, board.verdicts_due.size());
            board.errors++;
        end

        $display("testbench: %0d vertex words over %0d margin settings, %0d results checked",
                 words_sent, margins_set, board.checked);
        $display("testbench: %0d results inside, %0d near an edge, %0d errors",
                 board.inside_cnt, board.near_cnt, board.errors);
        if (board.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
